// ----- hdl/rusb_pkg.sv -----
// shared types and constants for the ray versus unit box slab test
// no dependencies
package rusb_pkg;

  // quotient magnitude bits kept by the divider (saturation covers the rest)
  localparam int Q_W           = 33;
  localparam int STEPS_PER_STG = 3;
  localparam int STEP_STAGES   = Q_W / STEPS_PER_STG;
  localparam int DIV_STAGES    = STEP_STAGES + 1;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  localparam logic CFG_ANY_HIT = 1'b0;
  localparam logic CFG_EPSILON = 1'b1;

  // per word control that rides alongside the divider lanes
  typedef struct packed {
    logic [2:0]  par;
    logic [2:0]  oout;
    logic [5:0]  neg;
    logic [30:0] best;
  } side_t;

endpackage

// ----- hdl/rusb_div.sv -----
// pipelined unsigned restoring divider, one slab distance per lane
// depends on rusb_pkg; stage enables come from the top level
module rusb_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic [rusb_pkg::DIV_STAGES-1:0]   en,
  input  logic [rusb_pkg::Q_W+FRAC_BITS-1:0] num_mag,
  input  logic [31:0]                       den_mag,
  output logic [rusb_pkg::Q_W-1:0]          q_mag,
  output logic                              ovf
);
  import rusb_pkg::*;

  localparam int NUM_W = Q_W + FRAC_BITS;

  logic [31:0]    rem_r [0:DIV_STAGES-1];
  logic [31:0]    den_r [0:DIV_STAGES-1];
  logic [Q_W-1:0] low_r [0:DIV_STAGES-1];
  logic [Q_W-1:0] q_r   [0:DIV_STAGES-1];
  logic           ovf_r [0:DIV_STAGES-1];

  // high part must stay below the divisor or the quotient exceeds Q_W bits
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= 32'(num_mag[NUM_W-1:Q_W]);
      low_r[0] <= num_mag[Q_W-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den_mag;
      ovf_r[0] <= (32'(num_mag[NUM_W-1:Q_W]) >= den_mag);
    end
  end

  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_stg
    logic [31:0]    rem_nxt;
    logic [Q_W-1:0] low_nxt;
    logic [Q_W-1:0] q_nxt;

    always_comb begin
      logic [32:0] t;
      t       = '0;
      rem_nxt = rem_r[j-1];
      low_nxt = low_r[j-1];
      q_nxt   = q_r[j-1];
      for (int k = 0; k < STEPS_PER_STG; k++) begin
        t       = {rem_nxt, low_nxt[Q_W-1]};
        low_nxt = {low_nxt[Q_W-2:0], 1'b0};
        if (t >= {1'b0, den_r[j-1]}) begin
          t     = t - {1'b0, den_r[j-1]};
          q_nxt = {q_nxt[Q_W-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[Q_W-2:0], 1'b0};
        end
        rem_nxt = t[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= rem_nxt;
        low_r[j] <= low_nxt;
        q_r[j]   <= q_nxt;
        den_r[j] <= den_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign q_mag = q_r[DIV_STAGES-1];
  assign ovf   = ovf_r[DIV_STAGES-1];

endmodule

// ----- hdl/ray_unit_box_slab_test.sv -----
// one word per cycle throughput while out_stall is low, set by the 12 stage divider
// pipeline (a load stage, then 3 quotient bits per stage)
// each stage advances when empty or when the stage after it moves, so bubbles
// collapse and a stalled output only holds the words behind it
// synchronous active-low reset clears valid bits, any_hit_mode=0, epsilon=7
module ray_unit_box_slab_test #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  logic [30:0]        in_best_distance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [30:0]        out_hit_distance
);
  import rusb_pkg::*;

  localparam int NUM_W = Q_W + FRAC_BITS;
  localparam int NST   = DIV_STAGES + 4;
  localparam int P1    = DIV_STAGES + 1;
  localparam int P2    = DIV_STAGES + 2;
  localparam logic signed [33:0] ONE_S = 34'(1) << FRAC_BITS;

  logic        any_hit_r;
  logic [15:0] eps_r;
  logic [NST-1:0] v_r;
  logic [NST-1:0] en_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_hit_r <= 1'b0;
      eps_r     <= 16'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANY_HIT: any_hit_r <= cfg_wdata[0];
        CFG_EPSILON: eps_r     <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    en_c[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en_c[k] = !v_r[k] || en_c[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en_c[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en_c[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_stall  = !en_c[0];
  assign out_valid = v_r[NST-1];

  // input register
  logic signed [31:0] o_r [3];
  logic signed [31:0] d_r [3];
  logic [30:0]        best_r;

  always_ff @(posedge clk) begin
    if (en_c[0]) begin
      o_r[0] <= in_origin_x;
      o_r[1] <= in_origin_y;
      o_r[2] <= in_origin_z;
      d_r[0] <= in_dir_x;
      d_r[1] <= in_dir_y;
      d_r[2] <= in_dir_z;
      best_r <= in_best_distance;
    end
  end

  // operand prep: lane 2a is the -1 plane, lane 2a+1 the +1 plane
  logic [NUM_W-1:0] num_c [6];
  logic [31:0]      den_c [6];
  side_t            side_c;

  always_comb begin
    logic signed [33:0] oe;
    logic signed [33:0] diff;
    logic [32:0]        absd;
    logic [31:0]        ad;
    oe   = '0;
    diff = '0;
    absd = '0;
    ad   = '0;
    side_c      = '0;
    side_c.best = best_r;
    for (int a = 0; a < 3; a++) begin
      oe = {{2{o_r[a][31]}}, o_r[a]};
      ad = d_r[a][31] ? 32'(-d_r[a]) : d_r[a];
      side_c.par[a]  = (ad < {16'd0, eps_r}) || (d_r[a] == '0);
      side_c.oout[a] = (oe < -ONE_S) || (oe > ONE_S);
      for (int p = 0; p < 2; p++) begin
        diff = (p == 0) ? (-ONE_S - oe) : (ONE_S - oe);
        absd = diff[33] ? 33'(-diff) : diff[32:0];
        num_c[2*a+p] = {absd, {FRAC_BITS{1'b0}}};
        den_c[2*a+p] = ad;
        side_c.neg[2*a+p] = diff[33] ^ d_r[a][31];
      end
    end
  end

  logic [Q_W-1:0] q_w   [6];
  logic           ovf_w [6];

  for (genvar l = 0; l < 6; l++) begin : g_lane
    rusb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk     (clk),
      .en      (en_c[DIV_STAGES:1]),
      .num_mag (num_c[l]),
      .den_mag (den_c[l]),
      .q_mag   (q_w[l]),
      .ovf     (ovf_w[l])
    );
  end

  side_t side_r [1:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en_c[1]) side_r[1] <= side_c;
    for (int k = 2; k <= DIV_STAGES; k++) begin
      if (en_c[k]) side_r[k] <= side_r[k-1];
    end
  end

  // saturate, order each slab pair, neutralize parallel axes
  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];
  logic               miss1_r;
  logic [30:0]        best1_r;
  logic signed [31:0] lo_c [3];
  logic signed [31:0] hi_c [3];
  logic               miss1_c;

  always_comb begin
    logic signed [31:0] t [2];
    side_t s;
    t[0] = '0;
    t[1] = '0;
    s       = side_r[DIV_STAGES];
    miss1_c = 1'b0;
    for (int a = 0; a < 3; a++) begin
      for (int p = 0; p < 2; p++) begin
        if (s.neg[2*a+p]) begin
          if (ovf_w[2*a+p] || q_w[2*a+p] > 33'h0_8000_0000) t[p] = SAT_MIN;
          else t[p] = 32'(-q_w[2*a+p]);
        end else begin
          if (ovf_w[2*a+p] || q_w[2*a+p][32:31] != 2'b00) t[p] = SAT_MAX;
          else t[p] = q_w[2*a+p][31:0];
        end
      end
      if (s.par[a]) begin
        lo_c[a] = SAT_MIN;
        hi_c[a] = SAT_MAX;
        if (s.oout[a]) miss1_c = 1'b1;
      end else if (t[0] > t[1]) begin
        lo_c[a] = t[1];
        hi_c[a] = t[0];
      end else begin
        lo_c[a] = t[0];
        hi_c[a] = t[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_c[P1]) begin
      lo_r    <= lo_c;
      hi_r    <= hi_c;
      miss1_r <= miss1_c;
      best1_r <= side_r[DIV_STAGES].best;
    end
  end

  // entry is the latest near plane, exit the earliest far plane
  logic signed [31:0] near_r, far_r;
  logic               miss2_r;
  logic [30:0]        best2_r;
  logic signed [31:0] near_c, far_c;

  always_comb begin
    near_c = lo_r[0];
    far_c  = hi_r[0];
    for (int a = 1; a < 3; a++) begin
      if (lo_r[a] > near_c) near_c = lo_r[a];
      if (hi_r[a] < far_c)  far_c  = hi_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en_c[P2]) begin
      near_r  <= near_c;
      far_r   <= far_c;
      miss2_r <= miss1_r || (near_c > far_c);
      best2_r <= best1_r;
    end
  end

  // pick distance and apply hit mode
  logic               hit_c;
  logic signed [31:0] sel_c;
  logic               out_hit_r;
  logic [30:0]        out_dist_r;

  always_comb begin
    logic signed [31:0] eps_s;
    eps_s = {16'd0, eps_r};
    hit_c = !miss2_r;
    sel_c = '0;
    priority if (near_r > eps_s) begin
      sel_c = near_r;
    end else if (far_r > eps_s) begin
      sel_c = far_r;
    end else begin
      hit_c = 1'b0;
    end
    if (!any_hit_r && !(sel_c > 0 && sel_c < $signed({1'b0, best2_r}))) hit_c = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en_c[NST-1]) begin
      out_hit_r  <= hit_c;
      out_dist_r <= hit_c ? sel_c[30:0] : '0;
    end
  end

  assign out_hit          = out_hit_r;
  assign out_hit_distance = out_dist_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_distance == '0)
    else $error("miss word carries a distance");

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[0] && out_valid)
    else $error("input stalled with free space");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid word after reset");

endmodule

// ----- dv/ray_box_checker.sv -----
// checker for the ray versus unit box slab test: watches both channels, predicts
// each result word from the accepted ray and compares it; depends on rusb_pkg
module ray_box_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  logic [30:0]        in_best_distance,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic [30:0]        out_hit_distance,
  output int                 fail_count,
  output int                 pending
);
  import rusb_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [30:0] hit_dist;
  } hit_word_t;

  hit_word_t  hit_q[$];
  logic       mode_any;
  logic [15:0] eps_reg;

  function automatic longint clamp32(longint v);
    if (v > longint'(SAT_MAX)) return longint'(SAT_MAX);
    if (v < longint'(SAT_MIN)) return longint'(SAT_MIN);
    return v;
  endfunction

  function automatic hit_word_t trace_ray(logic signed [31:0] o[3], logic signed [31:0] d[3],
                                          logic [30:0] best);
    longint one_v, eps, t_in, t_out, ta, tb, tmp, oi, di, ad, sel;
    bit ok;
    hit_word_t w;
    one_v = longint'(1) << FRAC_BITS;
    eps = longint'(eps_reg);
    t_in = longint'(SAT_MIN);
    t_out = longint'(SAT_MAX);
    ok = 1;
    sel = 0;
    for (int i = 0; i < 3; i++) begin
      if (ok) begin
        oi = longint'(o[i]);
        di = longint'(d[i]);
        ad = di < 0 ? -di : di;
        if (ad < eps || di == 0) begin
          if (oi < -one_v || oi > one_v) ok = 0;
        end else begin
          ta = clamp32(((-one_v - oi) * one_v) / di);
          tb = clamp32(((one_v - oi) * one_v) / di);
          if (ta > tb) begin
            tmp = ta; ta = tb; tb = tmp;
          end
          if (ta > t_in) t_in = ta;
          if (tb < t_out) t_out = tb;
          if (t_in > t_out) ok = 0;
        end
      end
    end
    if (ok) begin
      if (t_in > eps) sel = t_in;
      else if (t_out > eps) sel = t_out;
      else ok = 0;
    end
    if (ok && !mode_any && !(sel > 0 && sel < longint'(best))) ok = 0;
    w.hit = ok;
    w.hit_dist = ok ? sel[30:0] : '0;
    return w;
  endfunction

  assign pending = hit_q.size();

  always @(posedge clk) begin
    logic signed [31:0] o[3];
    logic signed [31:0] d[3];
    hit_word_t exp_w;
    if (!rst_n) begin
      mode_any <= 1'b0;
      eps_reg <= 16'd7;
      fail_count <= 0;
      hit_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        o[0] = in_origin_x; o[1] = in_origin_y; o[2] = in_origin_z;
        d[0] = in_dir_x; d[1] = in_dir_y; d[2] = in_dir_z;
        hit_q.push_back(trace_ray(o, d, in_best_distance));
      end
      if (out_valid && !out_stall) begin
        if (hit_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_w = hit_q.pop_front();
          if (out_hit !== exp_w.hit) begin
            $error("hit: expected %0d actual %0d", exp_w.hit, out_hit);
            fail_count <= fail_count + 1;
          end else if (out_hit_distance !== exp_w.hit_dist) begin
            $error("hit_distance: expected %0d actual %0d", exp_w.hit_dist,
                   out_hit_distance);
            fail_count <= fail_count + 1;
          end
        end
      end
      // register writes land after this edge's words were predicted
      if (cfg_we) begin
        if (cfg_index == CFG_ANY_HIT) mode_any <= cfg_wdata[0];
        else if (cfg_index == CFG_EPSILON) eps_reg <= cfg_wdata;
      end
    end
  end
endmodule

// ----- dv/tb_ray_unit_box_slab_test.sv -----
// testbench top for ray_unit_box_slab_test: directed and random rays, bursty
// sender, stalling receiver; depends on rusb_pkg and ray_box_checker
module tb_ray_unit_box_slab_test;
  import rusb_pkg::*;

  localparam int ONE = 1 << 16;
  localparam int LATENCY = 15;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_index = CFG_ANY_HIT;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_origin_x = 0, in_origin_y = 0, in_origin_z = 0;
  logic signed [31:0] in_dir_x = 0, in_dir_y = 0, in_dir_z = 0;
  logic [30:0] in_best_distance = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_hit;
  logic [30:0] out_hit_distance;
  int fail_count, pending;
  bit stall_on = 1;

  always #2 clk = ~clk;

  ray_unit_box_slab_test dut (.*);
  ray_box_checker chk (.*);

  // receiver stall pattern: runs of stall and free of random length
  always @(posedge clk) begin
    if (!stall_on) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 4 * ONE) - 2 * ONE;
      2: return $urandom_range(0, 64) - 32;
      3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      4: return $urandom_range(0, 40 * ONE) - 20 * ONE;
      default: return $urandom_range(0, 2) * ONE - ONE;
    endcase
  endfunction

  // present one ray word and hold it until accepted
  task automatic send_ray(logic [31:0] ox, oy, oz, dx, dy, dz, logic [30:0] best);
    in_valid <= 1'b1;
    in_origin_x <= ox; in_origin_y <= oy; in_origin_z <= oz;
    in_dir_x <= dx; in_dir_y <= dy; in_dir_z <= dz;
    in_best_distance <= best;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int burst;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 1)) idle_gap();
        burst = $urandom_range(1, 30);
      end
      burst--;
      send_ray(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), $urandom_range(0, 3) == 0 ? 31'h7fff_ffff : 31'($urandom()));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: axis hits, parallel inside/outside, extremes, behind, best limits
    send_ray(-3 * ONE, 0, 0, ONE, 0, 0, 31'h7fff_ffff);
    send_ray(0, 0, 0, 0, 0, ONE, 31'h7fff_ffff);
    send_ray(0, 0, 0, 0, 0, 0, 31'h7fff_ffff);
    send_ray(2 * ONE, 0, 0, 0, ONE, 0, 31'h7fff_ffff);
    send_ray(ONE, -ONE, ONE, 0, 0, 0, 31'h7fff_ffff);
    send_ray(3 * ONE, 0, 0, ONE, 0, 0, 31'h7fff_ffff);
    send_ray(-3 * ONE, 0, 0, ONE, 0, 0, 2 * ONE);
    send_ray(-3 * ONE, 0, 0, ONE, 0, 0, 2 * ONE + 1);
    send_ray(-3 * ONE, 0, 0, 6, 0, 0, 31'h7fff_ffff);
    send_ray(-3 * ONE, 0, 0, 1, ONE, 0, 31'h7fff_ffff);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff, 31'h7fff_ffff);
    send_ray(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, 31'h7fff_ffff);
    send_ray(-ONE, ONE, 0, 1, -1, 7, 0);
    send_ray(0, 0, ONE, 32'hffff_ffff, 7, -7, 31'h7fff_ffff);
    send_ray(ONE + 1, 0, 0, 0, 0, ONE, 31'h7fff_ffff);
    in_valid <= 1'b0;
    drain();
    random_phase(500);
    drain();
    write_reg(CFG_ANY_HIT, 16'd1);
    write_reg(CFG_EPSILON, 16'hffff);
    random_phase(500);
    drain();
    write_reg(CFG_EPSILON, 16'd0);
    random_phase(500);
    drain();
    write_reg(CFG_ANY_HIT, 16'd0);
    write_reg(CFG_EPSILON, 16'd300);
    stall_on = 0;
    random_phase(250);
    stall_on = 1;
    random_phase(250);
    drain();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/rusb_pkg.sv
hdl/rusb_div.sv
hdl/ray_unit_box_slab_test.sv
dv/ray_box_checker.sv
dv/tb_ray_unit_box_slab_test.sv
